// File: rtl/opsf_pkg.sv
// Shared constants, types and helper functions for the opaque stipple pixel fill.
`timescale 1ns / 1ps

package opsf_pkg;

	// Number of stipple rows held, which is also the largest tile extent.
	localparam int MAX_TILE = 32;
	localparam int ROW_W    = $clog2(MAX_TILE);
	localparam int ROW_BITS = 32;

	localparam logic [5:0]  TILE_MAX_6 = 6'(MAX_TILE);
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
	localparam logic [23:0] COLOUR_ZERO = 24'h000000;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		REG_FORE_COLOUR    = 3'd0,
		REG_BACK_COLOUR    = 3'd1,
		REG_PLANE_SELECT   = 3'd2,
		REG_STIPPLE_ON     = 3'd3,
		REG_TILE_WIDTH     = 3'd4,
		REG_TILE_HEIGHT    = 3'd5,
		REG_SURFACE_WIDTH  = 3'd6,
		REG_SURFACE_HEIGHT = 3'd7
	} reg_idx_t;

	// One item as it travels down the remainder stages.
	typedef struct packed {
		logic        operation;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [31:0] old_pixel;
		logic [4:0]  row_number;
		logic [31:0] row_pattern;
		logic        out_of_bounds;
		logic [5:0]  rem_x;
		logic [5:0]  rem_y;
	} stage_t;

	// A tile size of zero behaves as one; anything above the store depth saturates.
	function automatic logic [5:0] tile_extent(input logic [5:0] v);
		logic [5:0] e;
		if (v == 6'd0) begin
			e = 6'd1;
		end else if (v > TILE_MAX_6) begin
			e = TILE_MAX_6;
		end else begin
			e = v;
		end
		return e;
	endfunction

	// Four steps of a restoring remainder: the partial remainder stays below the divisor.
	function automatic logic [5:0] rem_step4(input logic [5:0] r, input logic [3:0] bits,
		input logic [5:0] d);
		logic [6:0] t;
		logic [5:0] acc;
		acc = r;
		for (int i = 3; i >= 0; i--) begin
			t = {acc, bits[i]};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
			end
			acc = t[5:0];
		end
		return acc;
	endfunction

endpackage

// File: rtl/opsf_if.sv
// Handshake channel interfaces for the pixel input and the pixel result.
`timescale 1ns / 1ps

interface opsf_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [31:0] old_pixel;
	logic [4:0]  row_number;
	logic [31:0] row_pattern;

	modport source(output valid, operation, pos_x, pos_y, old_pixel, row_number, row_pattern,
		input ready);
	modport sink(input valid, operation, pos_x, pos_y, old_pixel, row_number, row_pattern,
		output ready);
endinterface

interface opsf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] new_pixel;
	logic        write_enable;

	modport source(output valid, new_pixel, write_enable, input ready);
	modport sink(input valid, new_pixel, write_enable, output ready);
endinterface

// File: rtl/opsf_stipple_store.sv
// Stipple row store: one row written per load, one bit read per pixel.
`timescale 1ns / 1ps

module opsf_stipple_store
	import opsf_pkg::*;
(
	input  logic                clk,
	input  logic                wr_en,
	input  logic [4:0]          wr_row,
	input  logic [ROW_BITS-1:0] wr_data,
	input  logic [5:0]          rd_row,
	input  logic [5:0]          rd_col,
	output logic                rd_bit
);

	logic [ROW_BITS-1:0] rows_q [MAX_TILE];
	logic [ROW_BITS-1:0] row_word;

	// Rows have no reset: a row must be loaded before a pixel reads it.
	always_ff @(posedge clk) begin
		if (wr_en && ({1'b0, wr_row} < TILE_MAX_6)) begin
			rows_q[wr_row[ROW_W-1:0]] <= wr_data;
		end
	end

	always_comb begin
		row_word = '0;
		if (rd_row < TILE_MAX_6) begin
			row_word = rows_q[rd_row[ROW_W-1:0]];
		end
		rd_bit = 1'b0;
		if (rd_col < 6'(ROW_BITS)) begin
			rd_bit = row_word[rd_col[4:0]];
		end
	end

endmodule

// File: rtl/opaque_stipple_pixel_fill.sv
// Top level of the opaque stipple pixel fill with plane mask.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake      Carries
//  pix_in    sink       valid/ready    operation, pos_x, pos_y, old_pixel, row_number, row_pattern
//  pix_out   source     valid/ready    new_pixel, write_enable
//  cfg       write      cfg_we         cfg_index selects the register, cfg_data the value
//
// One item is taken per clock while pix_out does not stall, and each gives exactly one result
// from the stage five register. The cost sits in the tile remainders of x and y, worked out four
// bits per stage over stages one to four; stage five reads the stipple store and merges.
// Reset clears the valid bits and presets the settings; stipple rows are undefined until loaded.
// Every stage holds its item while the stage after it cannot take it, so a stall on pix_out
// fills bubbles first and then backs up to pix_in without loss or repetition.

module opaque_stipple_pixel_fill
	import opsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	opsf_in_if.sink     pix_in,
	opsf_out_if.source  pix_out,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	// Configuration registers.
	logic [23:0] fore_colour_q;
	logic [23:0] back_colour_q;
	logic [23:0] plane_select_q;
	logic        stipple_on_q;
	logic [5:0]  tile_width_q;
	logic [5:0]  tile_height_q;
	logic [15:0] surface_width_q;
	logic [15:0] surface_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_colour_q    <= 24'h000000;
			back_colour_q    <= 24'h000001;
			plane_select_q   <= 24'hffffff;
			stipple_on_q     <= 1'b0;
			tile_width_q     <= 6'd1;
			tile_height_q    <= 6'd1;
			surface_width_q  <= 16'd0;
			surface_height_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FORE_COLOUR:    fore_colour_q    <= cfg_data;
				REG_BACK_COLOUR:    back_colour_q    <= cfg_data;
				REG_PLANE_SELECT:   plane_select_q   <= cfg_data;
				REG_STIPPLE_ON:     stipple_on_q     <= cfg_data[0];
				REG_TILE_WIDTH:     tile_width_q     <= cfg_data[5:0];
				REG_TILE_HEIGHT:    tile_height_q    <= cfg_data[5:0];
				REG_SURFACE_WIDTH:  surface_width_q  <= cfg_data[15:0];
				REG_SURFACE_HEIGHT: surface_height_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The user settles tile extents only while the block is idle; this is not enforced.
	logic [5:0] div_x;
	logic [5:0] div_y;
	assign div_x = tile_extent(tile_width_q);
	assign div_y = tile_extent(tile_height_q);

	// Stage registers and their valid bits.
	stage_t s_s1, s_s2, s_s3, s_s4;
	logic   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [31:0] new_pixel_s5;
	logic        write_enable_s5;

	// A stage takes a new item when it is empty or its item moves on in the same cycle.
	logic take1, take2, take3, take4, take5;
	assign take5 = !v_s5 || pix_out.ready;
	assign take4 = !v_s4 || take5;
	assign take3 = !v_s3 || take4;
	assign take2 = !v_s2 || take3;
	assign take1 = !v_s1 || take2;
	assign pix_in.ready = take1;

	// Stage one: capture the item, check the surface bounds, first four remainder steps.
	stage_t in_item;
	always_comb begin
		in_item.operation     = pix_in.operation;
		in_item.pos_x         = pix_in.pos_x;
		in_item.pos_y         = pix_in.pos_y;
		in_item.old_pixel     = pix_in.old_pixel;
		in_item.row_number    = pix_in.row_number;
		in_item.row_pattern   = pix_in.row_pattern;
		in_item.out_of_bounds = (pix_in.pos_x >= surface_width_q) ||
			(pix_in.pos_y >= surface_height_q);
		in_item.rem_x         = rem_step4(6'd0, pix_in.pos_x[15:12], div_x);
		in_item.rem_y         = rem_step4(6'd0, pix_in.pos_y[15:12], div_y);
	end

	// Stages two to four each carry the remainders on by four more bits.
	stage_t nxt_s2, nxt_s3, nxt_s4;
	always_comb begin
		nxt_s2       = s_s1;
		nxt_s2.rem_x = rem_step4(s_s1.rem_x, s_s1.pos_x[11:8], div_x);
		nxt_s2.rem_y = rem_step4(s_s1.rem_y, s_s1.pos_y[11:8], div_y);
		nxt_s3       = s_s2;
		nxt_s3.rem_x = rem_step4(s_s2.rem_x, s_s2.pos_x[7:4], div_x);
		nxt_s3.rem_y = rem_step4(s_s2.rem_y, s_s2.pos_y[7:4], div_y);
		nxt_s4       = s_s3;
		nxt_s4.rem_x = rem_step4(s_s3.rem_x, s_s3.pos_x[3:0], div_x);
		nxt_s4.rem_y = rem_step4(s_s3.rem_y, s_s3.pos_y[3:0], div_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (take1) begin
				v_s1 <= pix_in.valid;
			end
			if (take2) begin
				v_s2 <= v_s1;
			end
			if (take3) begin
				v_s3 <= v_s2;
			end
			if (take4) begin
				v_s4 <= v_s3;
			end
			if (take5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take1) begin
			s_s1 <= in_item;
		end
		if (take2) begin
			s_s2 <= nxt_s2;
		end
		if (take3) begin
			s_s3 <= nxt_s3;
		end
		if (take4) begin
			s_s4 <= nxt_s4;
		end
	end

	// Stage five: loads write their row as they leave stage four, so a pixel behind a
	// load always sees the new row; pixels read the store on the same transfer.
	logic store_we;
	logic stipple_bit;
	assign store_we = v_s4 && take5 && (op_t'(s_s4.operation) == OP_LOAD);

	opsf_stipple_store u_store (
		.clk     (clk),
		.wr_en   (store_we),
		.wr_row  (s_s4.row_number),
		.wr_data (s_s4.row_pattern),
		.rd_row  (s_s4.rem_y),
		.rd_col  (s_s4.rem_x),
		.rd_bit  (stipple_bit)
	);

	logic        use_fore;
	logic [23:0] src_colour;
	logic [23:0] merged;
	logic        do_write;
	always_comb begin
		use_fore   = !stipple_on_q || stipple_bit;
		src_colour = use_fore ? fore_colour_q : back_colour_q;
		merged     = (src_colour & plane_select_q) | (s_s4.old_pixel[23:0] & ~plane_select_q);
		do_write   = (op_t'(s_s4.operation) == OP_PIXEL) && !s_s4.out_of_bounds;
	end

	always_ff @(posedge clk) begin
		if (take5) begin
			new_pixel_s5    <= do_write ? {ALPHA_OPAQUE, merged} : {8'h00, COLOUR_ZERO};
			write_enable_s5 <= do_write;
		end
	end

	assign pix_out.valid        = v_s5;
	assign pix_out.new_pixel    = new_pixel_s5;
	assign pix_out.write_enable = write_enable_s5;

endmodule

// File: tb/sv/tb_opaque_stipple_pixel_fill.sv
// Self-checking testbench for the opaque stipple pixel fill with plane mask.
`timescale 1ns / 1ps

// The testbench drives pixel and stipple-load items into the block through a
// valid/ready channel and checks every result against its own prediction.
// A clocked driver takes items from a backlog that the stimulus process fills.
// At each input transfer it works out the expected result and queues it.
// A clocked monitor compares each output transfer, field by field, with the
// oldest queued expectation. Configuration is only ever changed while the
// block is empty, between phases of stimulus.

module tb_opaque_stipple_pixel_fill
	import opsf_pkg::*;
();

	// One input item as the stimulus builds it.
	typedef struct {
		op_t         operation;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [31:0] old_pixel;
		logic [4:0]  row_number;
		logic [31:0] row_pattern;
	} fill_item_t;

	// One result item as the block should return it.
	typedef struct {
		logic [31:0] new_pixel;
		logic        write_enable;
	} fill_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	opsf_in_if  pix_in();
	opsf_out_if pix_out();

	opaque_stipple_pixel_fill dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix_in),
		.pix_out  (pix_out),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Our own copy of the configuration registers and the stipple store.
	logic [23:0] fore_rgb;
	logic [23:0] back_rgb;
	logic [23:0] plane_sel_rgb;
	logic        stipple_en;
	logic [5:0]  tile_w;
	logic [5:0]  tile_h;
	logic [15:0] surf_w;
	logic [15:0] surf_h;
	logic [31:0] stipple_store [MAX_TILE];

	fill_item_t   pixel_backlog[$];  // items waiting to be offered on pix_in
	fill_result_t due_pixels[$];     // results expected on pix_out, oldest first
	fill_item_t   on_wire;           // the item currently offered on pix_in

	int failures = 0;
	// While calm is set neither side idles, which gives a stretch at full rate.
	logic calm;
	// Each increment asks the hold-off process for one long stall on pix_out.
	int hold_requests;
	int holds_served;
	int hold_left;

	// Appends one item to the backlog of the driver.
	task automatic enqueue_item(fill_item_t it);
		pixel_backlog = {pixel_backlog, it};
	endtask

	// Predicts the result of one item and applies its effect on the stipple
	// store. A tile size of zero behaves as one and anything above the store
	// depth saturates at the depth; a column past the row bits reads as clear.
	function automatic fill_result_t fill_pixel(fill_item_t it);
		fill_result_t r;
		int ext_w;
		int ext_h;
		int col;
		int row;
		logic [23:0] src;
		logic fg;
		r.new_pixel = '0;
		r.write_enable = 1'b0;
		if (it.operation == OP_LOAD) begin
			if (int'(it.row_number) < MAX_TILE) begin
				stipple_store[it.row_number] = it.row_pattern;
			end
		end else if (it.pos_x < surf_w && it.pos_y < surf_h) begin
			ext_w = (tile_w == 0) ? 1 : ((int'(tile_w) > MAX_TILE) ? MAX_TILE : int'(tile_w));
			ext_h = (tile_h == 0) ? 1 : ((int'(tile_h) > MAX_TILE) ? MAX_TILE : int'(tile_h));
			col = int'(it.pos_x) % ext_w;
			row = int'(it.pos_y) % ext_h;
			fg = !stipple_en || (col < 32 && row < MAX_TILE && stipple_store[row][col]);
			src = fg ? fore_rgb : back_rgb;
			// Colour bits under the plane mask come from the source, the rest
			// from the old pixel; alpha is always opaque.
			r.new_pixel = {8'hff, (src & plane_sel_rgb) | (it.old_pixel[23:0] & ~plane_sel_rgb)};
			r.write_enable = 1'b1;
		end
		return r;
	endfunction

	// Driver: at each transfer the item on the wire is predicted, then the next
	// item is offered unless this cycle is chosen as a gap. The item and valid
	// are held steady for as long as the block is not ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_in.valid       <= 1'b0;
			pix_in.operation   <= OP_LOAD;
			pix_in.pos_x       <= '0;
			pix_in.pos_y       <= '0;
			pix_in.old_pixel   <= '0;
			pix_in.row_number  <= '0;
			pix_in.row_pattern <= '0;
		end else begin
			if (pix_in.valid && pix_in.ready) begin
				due_pixels = {due_pixels, fill_pixel(on_wire)};
			end
			if (!pix_in.valid || pix_in.ready) begin
				if (pixel_backlog.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
					on_wire = pixel_backlog.pop_front();
					pix_in.valid       <= 1'b1;
					pix_in.operation   <= on_wire.operation;
					pix_in.pos_x       <= on_wire.pos_x;
					pix_in.pos_y       <= on_wire.pos_y;
					pix_in.old_pixel   <= on_wire.old_pixel;
					pix_in.row_number  <= on_wire.row_number;
					pix_in.row_pattern <= on_wire.row_pattern;
				end else begin
					pix_in.valid <= 1'b0;
				end
			end
		end
	end

	// Hold-off: on request, keeps pix_out stalled while a countdown runs, so that the
	// pipeline fills and the block has to push back on pix_in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			holds_served <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_served != hold_requests) begin
			hold_left <= 300;
			holds_served <= hold_requests;
		end
	end

	// Monitor: every output transfer is checked against the oldest expectation,
	// then ready for the next cycle is chosen.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_out.ready <= 1'b0;
		end else begin
			if (pix_out.valid && pix_out.ready) begin
				if (due_pixels.size() == 0) begin
					$display("%0t: result with nothing expected, got new_pixel %08h write_enable %0b",
						$time, pix_out.new_pixel, pix_out.write_enable);
					failures++;
				end else begin
					if (pix_out.new_pixel !== due_pixels[0].new_pixel) begin
						$display("%0t: new_pixel mismatch, expected %08h, got %08h",
							$time, due_pixels[0].new_pixel, pix_out.new_pixel);
						failures++;
					end
					if (pix_out.write_enable !== due_pixels[0].write_enable) begin
						$display("%0t: write_enable mismatch, expected %0b, got %0b",
							$time, due_pixels[0].write_enable, pix_out.write_enable);
						failures++;
					end
					void'(due_pixels.pop_front());
				end
			end
			pix_out.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 23);
		end
	end

	// One register write, landing at the next rising edge. The enable is only
	// lowered by end_writes, so back-to-back writes keep it high throughout.
	task automatic write_reg(reg_idx_t idx, logic [23:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_FORE_COLOUR:    fore_rgb = value;
			REG_BACK_COLOUR:    back_rgb = value;
			REG_PLANE_SELECT:   plane_sel_rgb = value;
			REG_STIPPLE_ON:     stipple_en = value[0];
			REG_TILE_WIDTH:     tile_w = value[5:0];
			REG_TILE_HEIGHT:    tile_h = value[5:0];
			REG_SURFACE_WIDTH:  surf_w = value[15:0];
			REG_SURFACE_HEIGHT: surf_h = value[15:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// The sender pauses here until every expected result has come back, then
	// idles before returning. An item still offered on pix_in counts as
	// outstanding.
	task automatic settle();
		while (pixel_backlog.size() != 0 || due_pixels.size() != 0 || pix_in.valid) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	// Fields that a load does not use still get random values, and likewise
	// for a pixel, so that every input bit toggles.
	function automatic fill_item_t load_item(logic [4:0] row, logic [31:0] pattern);
		fill_item_t it;
		it.operation   = OP_LOAD;
		it.pos_x       = 16'($urandom);
		it.pos_y       = 16'($urandom);
		it.old_pixel   = $urandom;
		it.row_number  = row;
		it.row_pattern = pattern;
		return it;
	endfunction

	function automatic fill_item_t pixel_item(logic [15:0] x, logic [15:0] y, logic [31:0] old);
		fill_item_t it;
		it.operation   = OP_PIXEL;
		it.pos_x       = x;
		it.pos_y       = y;
		it.old_pixel   = old;
		it.row_number  = 5'($urandom);
		it.row_pattern = $urandom;
		return it;
	endfunction

	// Mostly inside the surface, with the edges on both sides of the bound
	// and the odd fully random value that reaches the top bits.
	function automatic logic [15:0] pick_coord(logic [15:0] bound);
		int k;
		k = $urandom_range(9);
		if (bound == 0 || k == 0) begin
			return 16'($urandom);
		end
		if (k == 1) begin
			return bound;
		end
		if (k == 2) begin
			return bound - 16'd1;
		end
		return 16'($urandom_range(int'(bound) - 1));
	endfunction

	function automatic logic [23:0] pick_colour();
		case ($urandom_range(3))
			0: return 24'h000000;
			1: return 24'hffffff;
			default: return 24'($urandom);
		endcase
	endfunction

	// Tile sizes include zero and values past the store depth.
	function automatic logic [5:0] pick_tile();
		case ($urandom_range(7))
			0: return 6'd0;
			1: return 6'd1;
			2: return 6'd32;
			3: return 6'd63;
			4: return 6'($urandom_range(63, 33));
			default: return 6'($urandom_range(32, 1));
		endcase
	endfunction

	function automatic logic [15:0] pick_surface();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'hffff;
			2: return 16'($urandom_range(40, 1));
			default: return 16'($urandom_range(16'hffff, 1));
		endcase
	endfunction

	task automatic shuffle_config();
		write_reg(REG_FORE_COLOUR, pick_colour());
		write_reg(REG_BACK_COLOUR, pick_colour());
		write_reg(REG_PLANE_SELECT, pick_colour());
		write_reg(REG_STIPPLE_ON, ($urandom_range(3) != 0) ? 24'd1 : 24'd0);
		write_reg(REG_TILE_WIDTH, 24'(pick_tile()));
		write_reg(REG_TILE_HEIGHT, 24'(pick_tile()));
		write_reg(REG_SURFACE_WIDTH, 24'(pick_surface()));
		write_reg(REG_SURFACE_HEIGHT, 24'(pick_surface()));
		end_writes();
	endtask

	// Random traffic: mostly pixels against the current surface, with loads
	// that rewrite the stipple while it is in use.
	task automatic random_phase(int count);
		logic [31:0] pattern;
		@(negedge clk);
		repeat (count) begin
			if ($urandom_range(4) == 0) begin
				case ($urandom_range(5))
					0: pattern = 32'h0000_0000;
					1: pattern = 32'hffff_ffff;
					default: pattern = $urandom;
				endcase
				enqueue_item(load_item(5'($urandom), pattern));
			end else begin
				enqueue_item(pixel_item(pick_coord(surf_w), pick_coord(surf_h), $urandom));
			end
		end
	endtask

	initial begin
		// Configuration inputs start at a known value, and our model at the reset state.
		cfg_we             = 1'b0;
		cfg_index          = REG_FORE_COLOUR;
		cfg_data           = '0;
		calm               = 1'b0;
		hold_requests      = 0;
		fore_rgb      = 24'h000000;
		back_rgb      = 24'h000001;
		plane_sel_rgb = 24'hffffff;
		stipple_en    = 1'b0;
		tile_w        = 6'd1;
		tile_h        = 6'd1;
		surf_w        = 16'd0;
		surf_h        = 16'd0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// At the reset settings the surface is empty, so no pixel is written.
		// Every stipple row is loaded here so that no row is ever read unwritten.
		@(negedge clk);
		enqueue_item(pixel_item(16'd0, 16'd0, $urandom));
		enqueue_item(pixel_item(16'hffff, 16'hffff, $urandom));
		for (int r = 0; r < MAX_TILE; r++) begin
			enqueue_item(load_item(5'(r), $urandom));
		end
		settle();

		// Full-size tile and surface, stipple on: corners of the tile and of
		// the surface, and the first coordinates past the surface.
		write_reg(REG_FORE_COLOUR, 24'hffffff);
		write_reg(REG_BACK_COLOUR, 24'h000000);
		write_reg(REG_PLANE_SELECT, 24'hffffff);
		write_reg(REG_STIPPLE_ON, 24'd1);
		write_reg(REG_TILE_WIDTH, 24'd32);
		write_reg(REG_TILE_HEIGHT, 24'd32);
		write_reg(REG_SURFACE_WIDTH, 24'h00ffff);
		write_reg(REG_SURFACE_HEIGHT, 24'h00ffff);
		end_writes();
		@(negedge clk);
		enqueue_item(load_item(5'd0, 32'hffff_ffff));
		enqueue_item(load_item(5'd31, 32'h8000_0001));
		enqueue_item(load_item(5'd5, 32'h0000_0000));
		enqueue_item(pixel_item(16'd0, 16'd0, 32'h0000_0000));
		enqueue_item(pixel_item(16'd31, 16'd31, 32'hffff_ffff));
		enqueue_item(pixel_item(16'd30, 16'd31, 32'hffff_ffff));
		enqueue_item(pixel_item(16'd0, 16'd5, 32'h0000_0000));
		enqueue_item(pixel_item(16'hfffe, 16'hfffe, 32'h00ff_00ff));
		enqueue_item(pixel_item(16'hffff, 16'd0, 32'h1234_5678));
		enqueue_item(pixel_item(16'd0, 16'hffff, 32'h1234_5678));
		enqueue_item(pixel_item(16'hffff, 16'hffff, 32'h1234_5678));
		settle();

		// Tile sizes of zero act as one, so every pixel reads row zero, column zero.
		write_reg(REG_TILE_WIDTH, 24'd0);
		write_reg(REG_TILE_HEIGHT, 24'd0);
		write_reg(REG_PLANE_SELECT, 24'h5a5a5a);
		write_reg(REG_FORE_COLOUR, 24'h123456);
		end_writes();
		@(negedge clk);
		enqueue_item(pixel_item(16'd7, 16'd9, 32'hffff_ffff));
		enqueue_item(pixel_item(16'hfffe, 16'd3, 32'h0000_0000));
		settle();

		// Oversized tiles saturate at the store depth; a plane mask of zero
		// keeps the old colour and only forces the alpha byte.
		write_reg(REG_TILE_WIDTH, 24'd63);
		write_reg(REG_TILE_HEIGHT, 24'd33);
		write_reg(REG_FORE_COLOUR, 24'h000000);
		write_reg(REG_BACK_COLOUR, 24'hffffff);
		write_reg(REG_PLANE_SELECT, 24'h000000);
		end_writes();
		@(negedge clk);
		enqueue_item(pixel_item(16'd63, 16'd95, 32'h00ab_cdef));
		enqueue_item(pixel_item(16'd62, 16'd94, 32'h7700_0000));
		settle();

		// Stipple off writes the foreground everywhere; a one-pixel surface
		// has a single writable coordinate.
		write_reg(REG_STIPPLE_ON, 24'd0);
		write_reg(REG_PLANE_SELECT, 24'hffffff);
		write_reg(REG_FORE_COLOUR, 24'habcdef);
		write_reg(REG_SURFACE_WIDTH, 24'd1);
		write_reg(REG_SURFACE_HEIGHT, 24'd1);
		end_writes();
		@(negedge clk);
		enqueue_item(pixel_item(16'd0, 16'd0, 32'h0000_0000));
		enqueue_item(pixel_item(16'd1, 16'd0, 32'h0000_0000));
		enqueue_item(pixel_item(16'd0, 16'd1, 32'h0000_0000));
		enqueue_item(pixel_item(16'd1, 16'd1, 32'hffff_ffff));
		settle();

		// Random phases, each under fresh settings. The third runs with no
		// idling on either side; during the fifth the output is held off for a
		// long stretch while the driver keeps offering items.
		for (int phase = 0; phase < 6; phase++) begin
			shuffle_config();
			@(negedge clk);
			calm <= (phase == 2);
			random_phase(66);
			if (phase == 4) begin
				hold_requests <= hold_requests + 1;
			end
			settle();
		end

		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Well beyond the slowest correct run, including the long hold-off.
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: opaque_stipple_pixel_fill.f
rtl/opsf_pkg.sv
rtl/opsf_if.sv
rtl/opsf_stipple_store.sv
rtl/opaque_stipple_pixel_fill.sv
tb/sv/tb_opaque_stipple_pixel_fill.sv
